// ----- hw/rtl/s2b_pkg.sv -----
// ----------------------------------------------------------------------------
// s2b_pkg
// Shared types, constants and helpers for the spline to Bezier converter.
// ----------------------------------------------------------------------------
package s2b_pkg;

  localparam int unsigned MAX_POINTS_DEF     = 16;
  localparam int unsigned COEF_FRAC_BITS_DEF = 12;
  localparam int unsigned PADDR_W            = 6;
  localparam int unsigned PDATA_W            = 64;
  localparam int unsigned COORD_W            = 16;
  localparam int unsigned SUM_W              = 35;

  typedef enum logic [2:0] {
    REG_COEF_ROW0 = 3'd0,
    REG_COEF_ROW1 = 3'd1,
    REG_COEF_ROW2 = 3'd2,
    REG_COEF_ROW3 = 3'd3,
    REG_CLOSED    = 3'd4,
    REG_END_DUP   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [3:0][PDATA_W-1:0] coef_row;
    logic                    closed_curve;
    logic [1:0]              end_duplicates;
  } cfg_t;

  typedef struct packed {
    logic       wr_en;
    logic       rd_en;
    logic [1:0] rd_slot;
    logic       mul_en;
    logic [2:0] mul_idx;
    logic       div_start;
    logic       out_load;
    logic [1:0] out_sel;
    logic       out_last;
    logic       out_status;
    logic       out_single;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_valid;
  } dp_sts_t;

  function automatic logic [COORD_W-1:0] sat16(input logic signed [47:0] v);
    logic [COORD_W-1:0] r;
    if (v > 48'sd32767) begin
      r = 16'h7fff;
    end else if (v < -48'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/s2b_regs.sv -----
// ----------------------------------------------------------------------------
// s2b_regs
// APB register file: basis matrix rows, closed curve flag, end duplicates.
// ----------------------------------------------------------------------------
module s2b_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [s2b_pkg::PADDR_W-1:0]   paddr,
  input  logic [s2b_pkg::PDATA_W-1:0]   pwdata,
  output logic [s2b_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output s2b_pkg::cfg_t                 cfg
);

  s2b_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = s2b_pkg::reg_idx_t'(paddr[s2b_pkg::PADDR_W-1:3]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_row       <= '0;
      cfg.closed_curve   <= 1'b0;
      cfg.end_duplicates <= 2'd2;
    end else if (wr) begin
      unique case (idx)
        s2b_pkg::REG_COEF_ROW0: cfg.coef_row[0]       <= pwdata;
        s2b_pkg::REG_COEF_ROW1: cfg.coef_row[1]       <= pwdata;
        s2b_pkg::REG_COEF_ROW2: cfg.coef_row[2]       <= pwdata;
        s2b_pkg::REG_COEF_ROW3: cfg.coef_row[3]       <= pwdata;
        s2b_pkg::REG_CLOSED:    cfg.closed_curve      <= pwdata[0];
        s2b_pkg::REG_END_DUP:   cfg.end_duplicates    <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      s2b_pkg::REG_COEF_ROW0: prdata = cfg.coef_row[0];
      s2b_pkg::REG_COEF_ROW1: prdata = cfg.coef_row[1];
      s2b_pkg::REG_COEF_ROW2: prdata = cfg.coef_row[2];
      s2b_pkg::REG_COEF_ROW3: prdata = cfg.coef_row[3];
      s2b_pkg::REG_CLOSED:    prdata = {{(s2b_pkg::PDATA_W-1){1'b0}}, cfg.closed_curve};
      s2b_pkg::REG_END_DUP:   prdata = {{(s2b_pkg::PDATA_W-2){1'b0}}, cfg.end_duplicates};
      default:                prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/s2b_div3.sv -----
// ----------------------------------------------------------------------------
// s2b_div3
// Four-lane floor division by three by reciprocal multiplication.
// ----------------------------------------------------------------------------
module s2b_div3 #(
  parameter int unsigned DW = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [3:0][DW-1:0]   din,
  output logic [3:0][DW-1:0]   quo,
  output logic                 busy
);

  localparam int unsigned UW = DW + 1;
  localparam int unsigned SH = UW + 2;
  localparam int unsigned PW = 2 * UW + 1;
  localparam logic [UW-1:0] OFFSET  = UW'(3) << (DW - 1);
  localparam logic [UW-1:0] KOFF    = UW'(1) << (DW - 1);
  localparam logic [SH:0]   POW     = (SH+1)'(1) << SH;
  localparam logic [SH:0]   RECIP_W = (POW + (SH+1)'(2)) / (SH+1)'(3);
  localparam logic [UW:0]   RECIP   = RECIP_W[UW:0];

  logic [3:0][UW-1:0] num;
  logic [3:0][UW-1:0] q;
  logic [3:0][PW-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= start;
    end
  end

  // offset keeps the dividend positive; the reciprocal is exact over its range
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      prod[l] = PW'(num[l]) * PW'(RECIP);
      quo[l]  = DW'(q[l] - KOFF);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      if (start) begin
        num[l] <= UW'($signed(din[l])) + OFFSET;
      end else if (busy) begin
        q[l] <= UW'(prod[l] >> SH);
      end
    end
  end

endmodule

// ----- hw/rtl/s2b_datapath.sv -----
// ----------------------------------------------------------------------------
// s2b_datapath
// Point store, knot window, basis multiply, Bezier conversion, output register.
// ----------------------------------------------------------------------------
module s2b_datapath #(
  parameter int unsigned MAX_POINTS     = s2b_pkg::MAX_POINTS_DEF,
  parameter int unsigned COEF_FRAC_BITS = s2b_pkg::COEF_FRAC_BITS_DEF,
  parameter int unsigned AW             = $clog2(MAX_POINTS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  s2b_pkg::dp_cmd_t      cmd,
  input  logic [AW-1:0]         wr_addr,
  input  logic [AW-1:0]         rd_addr,
  input  logic signed [15:0]    point_x,
  input  logic signed [15:0]    point_y,
  input  s2b_pkg::cfg_t         cfg,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic signed [15:0]    bez_x,
  output logic signed [15:0]    bez_y,
  output logic                  last_output,
  output logic                  status,
  output s2b_pkg::dp_sts_t      sts
);

  localparam int unsigned SW = s2b_pkg::SUM_W;
  localparam int unsigned QW = SW - COEF_FRAC_BITS;
  localparam int unsigned DW = QW + 1;
  localparam int unsigned BW = QW + 3;
  localparam logic signed [SW-1:0] HALF = SW'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [DW-1:0] ONE  = DW'(1);

  logic [31:0]              mem [MAX_POINTS];
  logic [3:0][31:0]         knot;
  logic signed [31:0]       prod [4];
  logic                     pval;
  logic [2:0]               pidx;
  logic signed [SW-1:0]     sum;
  logic signed [SW-1:0]     sum_sh;
  logic signed [QW-1:0]     cub [2][4];
  logic [3:0][DW-1:0]       din;
  logic [3:0][DW-1:0]       quo;
  logic signed [BW-1:0]     bz [2][4];
  logic [15:0]              sel_x;
  logic [15:0]              sel_y;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= {point_y, point_x};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      knot[cmd.rd_slot] <= mem[rd_addr];
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_mul
    logic signed [15:0] w;
    logic signed [15:0] k;
    assign w = cfg.coef_row[cmd.mul_idx[1:0]][16*c +: 16];
    assign k = cmd.mul_idx[2] ? knot[c][31:16] : knot[c][15:0];
    always_ff @(posedge clk) begin
      if (cmd.mul_en) begin
        prod[c] <= w * k;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pval <= 1'b0;
    end else begin
      pval <= cmd.mul_en;
    end
    pidx <= cmd.mul_idx;
  end

  assign sum    = SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]) + SW'(prod[3]) + HALF;
  assign sum_sh = sum >>> COEF_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (pval) begin
      cub[pidx[2]][~pidx[1:0]] <= sum_sh[QW-1:0];
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_axis
    assign din[2*a]   = DW'(cub[a][1]) + ONE;
    assign din[2*a+1] = DW'(cub[a][1]) + DW'(cub[a][2]) + ONE;
    assign bz[a][0] = BW'(cub[a][0]);
    assign bz[a][1] = bz[a][0] + BW'($signed(quo[2*a]));
    assign bz[a][2] = bz[a][1] + BW'($signed(quo[2*a+1]));
    assign bz[a][3] = BW'(cub[a][0]) + BW'(cub[a][1]) + BW'(cub[a][2]) + BW'(cub[a][3]);
  end

  s2b_div3 #(.DW(DW)) u_div3 (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .din   (din),
    .quo   (quo),
    .busy  (sts.div_busy)
  );

  always_comb begin
    if (cmd.out_single) begin
      sel_x = knot[0][15:0];
      sel_y = knot[0][31:16];
    end else begin
      sel_x = s2b_pkg::sat16(48'(bz[0][cmd.out_sel]));
      sel_y = s2b_pkg::sat16(48'(bz[1][cmd.out_sel]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      bez_x       <= sel_x;
      bez_y       <= sel_y;
      last_output <= cmd.out_last;
      status      <= cmd.out_status;
    end
  end

  assign sts.out_valid = out_valid;

endmodule

// ----- hw/rtl/s2b_ctrl.sv -----
// ----------------------------------------------------------------------------
// s2b_ctrl
// Sequencer: point intake, knot fetch, multiply, divide and emission steps.
// ----------------------------------------------------------------------------
module s2b_ctrl #(
  parameter int unsigned MAX_POINTS = s2b_pkg::MAX_POINTS_DEF,
  parameter int unsigned AW         = $clog2(MAX_POINTS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               last_point,
  input  logic               out_stall,
  input  s2b_pkg::cfg_t      cfg,
  input  s2b_pkg::dp_sts_t   sts,
  output logic               in_stall,
  output s2b_pkg::dp_cmd_t   cmd,
  output logic [AW-1:0]      wr_addr,
  output logic [AW-1:0]      rd_addr
);

  localparam int unsigned CNTW = $clog2(MAX_POINTS + 1);
  localparam int unsigned IW   = $clog2(MAX_POINTS + 8);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_MUL   = 5'b00100,
    S_DIV   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t          state;
  logic [CNTW-1:0] count;
  logic            overflow;
  logic [CNTW-1:0] n_pts;
  logic [IW-1:0]   nk;
  logic [IW-1:0]   seg;
  logic [1:0]      fc;
  logic [3:0]      mc;
  logic [1:0]      pk;
  logic            single;
  logic [1:0]      dd;

  logic            accept;
  logic            stored;
  logic [CNTW-1:0] n_next;
  logic [1:0]      d_cfg;
  logic            seg_last;
  logic            can_load;
  logic [IW-1:0]   ki;
  logic [IW-1:0]   ni;
  logic [IW-1:0]   di;
  logic [IW-1:0]   kk;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign stored   = (count < CNTW'(MAX_POINTS));
  assign n_next   = stored ? count + CNTW'(1) : count;
  assign d_cfg    = (cfg.end_duplicates < 2'd2) ? 2'd2 : cfg.end_duplicates;
  assign seg_last = (seg + IW'(4) == nk);
  assign can_load = !sts.out_valid || !out_stall;
  assign wr_addr  = count[AW-1:0];

  assign ki = seg + IW'(fc);
  assign ni = IW'(n_pts);
  assign di = IW'(dd);

  always_comb begin
    if (single) begin
      kk = '0;
    end else if (cfg.closed_curve) begin
      if (ki == '0) begin
        kk = ni - IW'(1);
      end else if (ki == ni + IW'(1)) begin
        kk = '0;
      end else if (ki == ni + IW'(2)) begin
        kk = IW'(1);
      end else begin
        kk = ki - IW'(1);
      end
    end else begin
      if (ki < di) begin
        kk = '0;
      end else if (ki >= ni + di - IW'(2)) begin
        kk = ni - IW'(1);
      end else begin
        kk = ki - di + IW'(1);
      end
    end
  end

  assign rd_addr = kk[AW-1:0];

  always_comb begin
    cmd            = '0;
    cmd.wr_en      = accept && stored;
    cmd.rd_slot    = fc;
    cmd.mul_idx    = mc[2:0];
    cmd.out_sel    = pk;
    cmd.out_status = overflow;
    cmd.out_single = single;
    cmd.out_last   = single || (seg_last && (pk == 2'd3));
    unique case (state)
      S_IDLE:  ;
      S_FETCH: cmd.rd_en = 1'b1;
      S_MUL: begin
        cmd.mul_en    = (mc < 4'd8);
        cmd.div_start = (mc == 4'd9);
      end
      S_DIV:   ;
      S_EMIT:  cmd.out_load = can_load;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      overflow <= 1'b0;
      n_pts    <= '0;
      nk       <= '0;
      seg      <= '0;
      fc       <= '0;
      mc       <= '0;
      pk       <= '0;
      single   <= 1'b0;
      dd       <= 2'd2;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (stored) begin
              count <= n_next;
            end else begin
              overflow <= 1'b1;
            end
            if (last_point) begin
              n_pts  <= n_next;
              single <= (n_next < CNTW'(2));
              dd     <= d_cfg;
              nk     <= cfg.closed_curve ? IW'(n_next) + IW'(3)
                                         : IW'(n_next) + IW'(2) * IW'(d_cfg) - IW'(2);
              seg    <= '0;
              fc     <= '0;
              state  <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          fc <= fc + 2'd1;
          if (fc == 2'd3) begin
            mc <= '0;
            pk <= '0;
            state <= single ? S_EMIT : S_MUL;
          end
        end
        S_MUL: begin
          mc <= mc + 4'd1;
          if (mc == 4'd9) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (!sts.div_busy) begin
            pk    <= (seg == '0) ? 2'd0 : 2'd1;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (can_load) begin
            if (single || pk == 2'd3) begin
              if (single || seg_last) begin
                count    <= '0;
                overflow <= 1'b0;
                state    <= S_IDLE;
              end else begin
                seg   <= seg + IW'(1);
                fc    <= '0;
                state <= S_FETCH;
              end
            end else begin
              pk <= pk + 2'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(MAX_POINTS))
    else $error("point count beyond storage");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(sts.out_valid && out_stall))
    else $error("output register overwritten while stalled");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider restarted while busy");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> (state == S_IDLE))
    else $error("point store written outside intake");

  a_curve_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && cmd.out_last) |=> (state == S_IDLE && count == '0 && !overflow))
    else $error("curve end did not clear intake state");

endmodule

// ----- hw/rtl/spline_to_bezier_converter.sv -----
// ----------------------------------------------------------------------------
// spline_to_bezier_converter
// Converts stored 2D spline control points into cubic Bezier points.
// ----------------------------------------------------------------------------
// Usage:
//   Configure the four basis matrix rows, closed_curve and end_duplicates
//   over APB (64-bit registers at 8*index) while the block is idle.
//   Control points enter on in_valid/in_stall, one per cycle while idle; a
//   point without last_point only goes into the point store. The point
//   marked last starts emission of the whole curve on out_valid/out_stall:
//   four points for the first segment, three for every later one, the last
//   flagged by last_output. in_stall stays high until the final point has
//   been loaded into the output register.
//   Per segment: knot reads (one store read port), matrix multiply (four
//   16x16 multipliers, one row per cycle), the divide-by-three unit
//   (reciprocal multiply), then one cycle per emitted point while the
//   receiver does not stall. A single stored point is emitted unchanged.
//   A stalled receiver holds the output register and pauses emission only.
//   Reset clears the point count, overflow flag and registers to defaults;
//   the point store holds stale data that is never read before written.
// ----------------------------------------------------------------------------
module spline_to_bezier_converter #(
  parameter int unsigned MAX_POINTS     = s2b_pkg::MAX_POINTS_DEF,
  parameter int unsigned COEF_FRAC_BITS = s2b_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [s2b_pkg::PADDR_W-1:0]   paddr,
  input  logic [s2b_pkg::PDATA_W-1:0]   pwdata,
  output logic [s2b_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [15:0]            point_x,
  input  logic signed [15:0]            point_y,
  input  logic                          last_point,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            bez_x,
  output logic signed [15:0]            bez_y,
  output logic                          last_output,
  output logic                          status
);

  localparam int unsigned AW = $clog2(MAX_POINTS);

  s2b_pkg::cfg_t     cfg;
  s2b_pkg::dp_cmd_t  cmd;
  s2b_pkg::dp_sts_t  sts;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;

  s2b_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  s2b_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .last_point (last_point),
    .out_stall  (out_stall),
    .cfg        (cfg),
    .sts        (sts),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr)
  );

  s2b_datapath #(
    .MAX_POINTS     (MAX_POINTS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .AW             (AW)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .wr_addr     (wr_addr),
    .rd_addr     (rd_addr),
    .point_x     (point_x),
    .point_y     (point_y),
    .cfg         (cfg),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .bez_x       (bez_x),
    .bez_y       (bez_y),
    .last_output (last_output),
    .status      (status),
    .sts         (sts)
  );

endmodule
